// ===== hw/rtl/urs_pkg.sv =====
`default_nettype none

package urs_pkg;

  // Default width of the elapsed tick counter.
  localparam int unsigned CounterBitsDef = 24;

  // Field widths.
  localparam int unsigned PulseW = 8;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned WidthW = 24;
  localparam int unsigned DistW = 24;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 56;

  // Fractional bits of the distance scale.
  localparam int unsigned ScaleFracBits = 16;

  // Register reset values.
  localparam logic [PulseW-1:0] PulseRst = PulseW'(10);
  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(58309);
  localparam logic [ScaleW-1:0] ScaleRst = ScaleW'(11239);

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegPulse = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale = 2'd2;

  // Phase codes.
  localparam logic [PhaseW-1:0] PhIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhTrig = 2'd1;
  localparam logic [PhaseW-1:0] PhWait = 2'd2;
  localparam logic [PhaseW-1:0] PhMeas = 2'd3;

  // Result of one tick, before the distance is worked out.
  typedef struct packed {
    logic                    trigger_level;
    logic                    measure_done;
    logic                    have_measurement;
    logic [WidthW-1:0]       echo_width_us;
    logic [PhaseW-1:0]       phase;
  } tick_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ultrasonic_range_sequencer.sv =====
// Trigger and echo timer for an ultrasonic rangefinder. Each input item is one
// microsecond tick carrying the sampled echo level; each accepted item yields
// exactly one result item with the trigger level, a capture pulse, the last echo
// width and the distance in millimetres. The block takes one item per clock
// cycle when the output side keeps up. Each result passes the first register
// stage, loaded on the accepting edge, which holds the phase and counter update,
// then the second, loaded when the output is free, which holds the 24x16
// distance multiply. The user must write configuration through the plain write
// port only while no items are in flight; the block itself does not enforce it.
`default_nettype none

module ultrasonic_range_sequencer #(
  parameter int unsigned COUNTER_BITS = urs_pkg::CounterBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [urs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [urs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Tick input; tdata: [0] echo_level, [7:1] zero.
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [urs_pkg::InDataW-1:0]   s_axis_tdata,
  // Results; tdata: [0] trigger_level, [1] measure_done, [2] have_measurement,
  // [26:3] echo_width_us, [50:27] distance_mm, [52:51] phase, [55:53] zero.
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [urs_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned CmpW =
    (COUNTER_BITS > urs_pkg::TimeoutW) ? COUNTER_BITS : urs_pkg::TimeoutW;
  localparam int unsigned ProdW = urs_pkg::WidthW + urs_pkg::ScaleW;

  // Configuration registers.
  logic [urs_pkg::PulseW-1:0]   pulse_q;
  logic [urs_pkg::TimeoutW-1:0] timeout_q;
  logic [urs_pkg::ScaleW-1:0]   scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q   <= urs_pkg::PulseRst;
      timeout_q <= urs_pkg::TimeoutRst;
      scale_q   <= urs_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        urs_pkg::RegPulse:   pulse_q   <= cfg_wdata_i[urs_pkg::PulseW-1:0];
        urs_pkg::RegTimeout: timeout_q <= cfg_wdata_i[urs_pkg::TimeoutW-1:0];
        urs_pkg::RegScale:   scale_q   <= cfg_wdata_i[urs_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_free, in_acc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_free       = !s1_valid_q || out_free;
  assign s_axis_tready = s1_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Sequencer state.
  logic [urs_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [COUNTER_BITS-1:0]    elapsed_q, elapsed_d;
  logic [urs_pkg::WidthW-1:0] width_q, width_d;
  logic                       have_q, have_d;
  logic                       done_d;

  logic                    echo;
  logic [COUNTER_BITS-1:0] inc;
  logic [CmpW-1:0]         inc_x;
  logic                    over_timeout, over_pulse;

  assign echo = s_axis_tdata[0];

  // Saturating increment of the elapsed counter and its limit compares.
  always_comb begin
    inc          = (elapsed_q == {COUNTER_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
    inc_x        = CmpW'(inc);
    over_timeout = inc_x > CmpW'(timeout_q);
    over_pulse   = inc_x > CmpW'(pulse_q);
  end

  // Phase transitions for one tick.
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = inc;
    width_d   = width_q;
    have_d    = have_q;
    done_d    = 1'b0;
    unique case (phase_q)
      urs_pkg::PhIdle: begin
        if (over_timeout) begin
          phase_d   = urs_pkg::PhTrig;
          elapsed_d = '0;
        end
      end
      urs_pkg::PhTrig: begin
        if (over_pulse) begin
          phase_d   = urs_pkg::PhWait;
          elapsed_d = '0;
        end
      end
      urs_pkg::PhWait: begin
        // A rising echo wins over the timeout on the same tick.
        priority if (echo) begin
          phase_d   = urs_pkg::PhMeas;
          elapsed_d = '0;
        end else if (over_timeout) begin
          phase_d   = urs_pkg::PhTrig;
          elapsed_d = '0;
        end
      end
      urs_pkg::PhMeas: begin
        if (!echo) begin
          width_d   = (inc_x > CmpW'({urs_pkg::WidthW{1'b1}})) ?
                      {urs_pkg::WidthW{1'b1}} : urs_pkg::WidthW'(inc_x);
          have_d    = 1'b1;
          done_d    = 1'b1;
          phase_d   = urs_pkg::PhTrig;
          elapsed_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= urs_pkg::PhIdle;
      elapsed_q <= '0;
      width_q   <= '0;
      have_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      width_q   <= width_d;
      have_q    <= have_d;
    end
  end

  // First stage: the tick result without the distance.
  urs_pkg::tick_res_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.trigger_level    <= (phase_d == urs_pkg::PhTrig);
      s1_q.measure_done     <= done_d;
      s1_q.have_measurement <= have_d;
      s1_q.echo_width_us    <= width_d;
      s1_q.phase            <= phase_d;
    end
  end

  // Second stage: distance multiply into the output register.
  logic [ProdW-1:0]          prod;
  urs_pkg::tick_res_t        out_q;
  logic [urs_pkg::DistW-1:0] dist_q;

  // The product of a 24-bit width and a Q0.16 scale, shifted, always fits 24 bits.
  assign prod = ProdW'(s1_q.echo_width_us) * ProdW'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_q  <= s1_q;
      dist_q <= prod[urs_pkg::ScaleFracBits +: urs_pkg::DistW];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.phase, dist_q, out_q.echo_width_us,
                          out_q.have_measurement, out_q.measure_done,
                          out_q.trigger_level};

  // A capture always leaves a valid measurement and a fresh trigger behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && done_d) |=> (have_q && phase_q == urs_pkg::PhTrig))
    else $error("capture did not retrigger");

  // Once a measurement exists it never goes away.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(have_q))
    else $error("measurement flag dropped");

  // The trigger pulse only ends by moving to the echo wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == urs_pkg::PhTrig) |=>
      (phase_q == urs_pkg::PhTrig || phase_q == urs_pkg::PhWait))
    else $error("bad exit from trigger phase");

  // The sequencer state moves only on an accepted tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> ($stable(elapsed_q) && $stable(phase_q)))
    else $error("state changed without a tick");

  // A staged result is never overwritten while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage one lost an item");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import urs_pkg::*;

  // Index that maps to no register; writes to it must leave everything alone.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // Bit positions inside the result tdata.
  localparam int unsigned TrigBit = 0;
  localparam int unsigned DoneBit = 1;
  localparam int unsigned HaveBit = 2;
  localparam int unsigned WidthLsb = 3;
  localparam int unsigned DistLsb = WidthLsb + WidthW;
  localparam int unsigned PhaseLsb = DistLsb + DistW;
  localparam int unsigned PadLsb = PhaseLsb + PhaseW;

  localparam logic [WidthW-1:0] WidthSat = '1;
  localparam logic [CounterBitsDef-1:0] ElapsedSat = '1;

  typedef struct {
    logic              trigger_level;
    logic              measure_done;
    logic              have_measurement;
    logic [WidthW-1:0] echo_width_us;
    logic [DistW-1:0]  distance_mm;
    logic [PhaseW-1:0] phase;
  } range_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the sequencer's registers and state.
  logic [PulseW-1:0]         pulse_len_q;
  logic [TimeoutW-1:0]       timeout_q;
  logic [ScaleW-1:0]         scale_q;
  logic [PhaseW-1:0]         phase_q;
  logic [CounterBitsDef-1:0] elapsed_q;
  logic [WidthW-1:0]         width_q;
  logic                      width_valid_q;

  range_result_t pending_results[$];

  int unsigned error_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned captures_seen = 0;
  int unsigned retriggers_seen = 0;
  bit          gaps_enabled = 1'b1;
  int unsigned stall_left = 0;

  ultrasonic_range_sequencer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the handshake hangs.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_failure(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      report_failure($sformatf("%s expected %0d got %0d", name, want, got));
    end
  endtask

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_enabled || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow state by one tick and return what the block reports.
  function automatic range_result_t next_range_result(input logic echo);
    logic [CounterBitsDef-1:0] count;
    logic [63:0]               product;
    range_result_t             r;
    count = (elapsed_q == ElapsedSat) ? elapsed_q : elapsed_q + 1'b1;
    r.measure_done = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (count > timeout_q) begin
          phase_q = PhTrig;
          count = '0;
        end
      end
      PhTrig: begin
        if (count > pulse_len_q) begin
          phase_q = PhWait;
          count = '0;
        end
      end
      PhWait: begin
        // A rising echo wins over a timeout on the same tick.
        if (echo) begin
          phase_q = PhMeas;
          count = '0;
        end else if (count > timeout_q) begin
          phase_q = PhTrig;
          count = '0;
        end
      end
      default: begin
        if (!echo) begin
          width_q = (count > WidthSat) ? WidthSat : WidthW'(count);
          width_valid_q = 1'b1;
          r.measure_done = 1'b1;
          phase_q = PhTrig;
          count = '0;
        end
      end
    endcase
    elapsed_q = count;
    product = (64'(width_q) * 64'(scale_q)) >> ScaleFracBits;
    r.distance_mm = (product > 64'(WidthSat)) ? WidthSat : DistW'(product);
    r.trigger_level = (phase_q == PhTrig);
    r.have_measurement = width_valid_q;
    r.echo_width_us = width_q;
    r.phase = phase_q;
    return r;
  endfunction

  // Send one tick and queue its expected result once it is accepted.
  task automatic send_tick(input logic echo);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW-1){1'b0}}, echo};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_results.push_back(next_range_result(echo));
    ticks_sent++;
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic wait_until_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegPulse:   pulse_len_q = data[PulseW-1:0];
      RegTimeout: timeout_q = data[TimeoutW-1:0];
      RegScale:   scale_q = data[ScaleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_ranging(input int unsigned pulse, input int unsigned timeout,
                                 input int unsigned scale);
    write_reg(RegPulse, CfgDataW'(pulse));
    write_reg(RegTimeout, CfgDataW'(timeout));
    write_reg(RegScale, CfgDataW'(scale));
  endtask

  // Echo traffic shaped like real returns: alternating low and high runs,
  // with a share of single random ticks mixed in as noise.
  task automatic drive_echo_bursts(input int unsigned n_ticks, input int unsigned noise_pct);
    int unsigned sent;
    int unsigned run_len;
    logic        level;
    sent = 0;
    level = 1'b0;
    while (sent < n_ticks) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_tick(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if (level) begin
          run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                : $urandom_range(1, 30);
        end else begin
          run_len = $urandom_range(1, 40);
        end
        if (run_len > n_ticks - sent) begin
          run_len = n_ticks - sent;
        end
        repeat (run_len) send_tick(level);
        sent += run_len;
        level = ~level;
      end
    end
  endtask

  // Output side: random stalls driven at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    range_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result item with none expected, tdata %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.measure_done) captures_seen++;
        if (want.trigger_level && !want.measure_done && want.phase == PhTrig
            && want.echo_width_us == width_q) retriggers_seen++;
        compare_field("trigger_level", 32'(want.trigger_level), 32'(m_axis_tdata[TrigBit]));
        compare_field("measure_done", 32'(want.measure_done), 32'(m_axis_tdata[DoneBit]));
        compare_field("have_measurement", 32'(want.have_measurement),
                      32'(m_axis_tdata[HaveBit]));
        compare_field("echo_width_us", 32'(want.echo_width_us),
                      32'(m_axis_tdata[WidthLsb +: WidthW]));
        compare_field("distance_mm", 32'(want.distance_mm),
                      32'(m_axis_tdata[DistLsb +: DistW]));
        compare_field("phase", 32'(want.phase), 32'(m_axis_tdata[PhaseLsb +: PhaseW]));
        compare_field("padding", 32'd0, 32'(m_axis_tdata[OutDataW-1:PadLsb]));
      end
    end
  end

  // Echo activity in idle is ignored while the counter runs toward the default timeout.
  task automatic test_power_on_defaults();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_until_quiet();
  endtask

  // Shortest pulse and timeout, full scale: the one-tick echo, a timeout
  // retrigger and an echo that rises on the very tick the timeout expires.
  task automatic test_fastest_ranging();
    logic [15:0] pattern;
    program_ranging(1, 1, 16'hFFFF);
    pattern = 16'b0100_0000_0011_0000;
    for (int i = 0; i < 16; i++) begin
      send_tick(pattern[i]);
    end
    wait_until_quiet();
  endtask

  // Longest pulse, a timeout that can never fire, zero scale and a stray write.
  task automatic test_slow_pulse_zero_scale();
    program_ranging(255, 24'hFFFFFF, 0);
    write_reg(RegUnused, CfgDataW'($urandom));
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_until_quiet();
  endtask

  task automatic test_short_windows();
    program_ranging(1, 1, 16'hFFFF);
    drive_echo_bursts(200, 10);
    wait_until_quiet();
    program_ranging($urandom_range(1, 20), $urandom_range(2, 50), $urandom_range(0, 65535));
    drive_echo_bursts(200, 10);
    wait_until_quiet();
  endtask

  task automatic test_long_pulse();
    program_ranging(255, $urandom_range(200, 400), $urandom_range(0, 65535));
    drive_echo_bursts(220, 5);
    wait_until_quiet();
  endtask

  // Back-to-back items with no stalls on either side.
  task automatic test_back_to_back();
    gaps_enabled = 1'b0;
    program_ranging($urandom_range(1, 8), $urandom_range(1, 30), ScaleRst);
    drive_echo_bursts(210, 10);
    wait_until_quiet();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_noisy_echo();
    program_ranging($urandom_range(1, 255), $urandom_range(1, 60), $urandom_range(0, 65535));
    drive_echo_bursts(210, 70);
    wait_until_quiet();
  endtask

  task automatic test_zero_scale_bursts();
    program_ranging($urandom_range(1, 12), $urandom_range(1, 100), 0);
    drive_echo_bursts(200, 15);
    wait_until_quiet();
  endtask

  initial begin
    pulse_len_q = PulseRst;
    timeout_q = TimeoutRst;
    scale_q = ScaleRst;
    phase_q = PhIdle;
    elapsed_q = '0;
    width_q = '0;
    width_valid_q = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_on_defaults();
    test_fastest_ranging();
    test_slow_pulse_zero_scale();
    test_short_windows();
    test_long_pulse();
    test_back_to_back();
    test_noisy_echo();
    test_zero_scale_bursts();

    if (pending_results.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    $display("Covered %0d ticks, %0d results checked, %0d echo widths captured.",
             ticks_sent, results_checked, captures_seen);
    $display("Settings swept: pulse 1..255, timeout 1..max, scale 0..max; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/urs_pkg.sv
hw/rtl/ultrasonic_range_sequencer.sv
bench/testbench.sv
